[design/wfc_pkg.sv]
// Shared types and constants for the wall-follow controller.
// Depends on nothing; the other design files except wfc_chan_if refer to it by scoped names.
`timescale 1ns / 1ps

package wfc_pkg;

    localparam int DIST_W     = 8;
    localparam int SPEED_W    = 10;
    localparam int CMD_W      = 3;
    localparam int STAGE_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Wall side codes, also used as the last-turn marker
    typedef enum logic [1:0] {
        WALL_LEFT   = 2'd0,
        WALL_CENTER = 2'd1,
        WALL_RIGHT  = 2'd2,
        WALL_NONE   = 2'd3
    } t_wall;

    // Motor command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_NONE  = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_FWD   = 3'd2,
        CMD_LEFT  = 3'd3,
        CMD_RIGHT = 3'd4
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRUISE_SPEED  = 3'd0,
        CFG_SEARCH_LOW    = 3'd1,
        CFG_SEARCH_HIGH   = 3'd2,
        CFG_HOLD_LOW      = 3'd3,
        CFG_HOLD_HIGH     = 3'd4,
        CFG_OBSTACLE_NEAR = 3'd5,
        CFG_ROTATE_SPEED  = 3'd6
    } t_cfg_idx;

    // Configuration reset values
    localparam logic [SPEED_W-1:0] RST_CRUISE_SPEED  = 10'd190;
    localparam logic [DIST_W-1:0]  RST_SEARCH_LOW    = 8'd30;
    localparam logic [DIST_W-1:0]  RST_SEARCH_HIGH   = 8'd45;
    localparam logic [DIST_W-1:0]  RST_HOLD_LOW      = 8'd35;
    localparam logic [DIST_W-1:0]  RST_HOLD_HIGH     = 8'd45;
    localparam logic [DIST_W-1:0]  RST_OBSTACLE_NEAR = 8'd45;
    localparam logic [SPEED_W-1:0] RST_ROTATE_SPEED  = 10'd90;
    localparam logic [DIST_W-1:0]  RST_MIN_DIST      = 8'd255;

    typedef struct packed {
        logic [SPEED_W-1:0] cruise_speed;
        logic [DIST_W-1:0]  search_low;
        logic [DIST_W-1:0]  search_high;
        logic [DIST_W-1:0]  hold_low;
        logic [DIST_W-1:0]  hold_high;
        logic [DIST_W-1:0]  obstacle_near;
        logic [SPEED_W-1:0] rotate_speed;
    } t_cfg;

    // Input beat: one sensor tick
    typedef struct packed {
        logic [DIST_W-1:0] dist_left;
        logic [DIST_W-1:0] dist_center;
        logic [DIST_W-1:0] dist_right;
    } t_sens;

    // Output beat: one motor command
    typedef struct packed {
        logic [CMD_W-1:0]   motor_command;
        logic [SPEED_W-1:0] motor_speed;
        logic [STAGE_W-1:0] stage_now;
    } t_motor;

    // Classified tick passed from front to back
    typedef struct packed {
        t_wall             wall;
        logic [DIST_W-1:0] min_dist;
        logic              hold_on;
        logic              hold_far;
        logic              obst;
    } t_cls;

endpackage

[design/wfc_chan_if.sv]
// Valid/ready stream channel carrying one typed payload per beat.
// Depends on nothing; payload types come from wfc_pkg at the instance.
`timescale 1ns / 1ps

interface wfc_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/wfc_front.sv]
// Front end: accepts sensor beats and classifies them (nearest wall, bounds).
// Depends on wfc_pkg and wfc_chan_if.
`timescale 1ns / 1ps

module wfc_front (
    wfc_chan_if.sink      i_sens,
    input  wfc_pkg::t_cfg i_cfg,
    input  logic          i_q_full,
    output logic          o_push,
    output wfc_pkg::t_cls o_cls
);

    logic [wfc_pkg::DIST_W-1:0] l, c, r;

    assign l = i_sens.data.dist_left;
    assign c = i_sens.data.dist_center;
    assign r = i_sens.data.dist_right;

    // Accept whenever the queue has room
    assign i_sens.ready = !i_q_full;
    assign o_push       = i_sens.valid && !i_q_full;

    // Pick the nearest wall; a left/right tie not above center goes left
    always_comb begin
        o_cls = '0;
        if (l <= c && l < r) begin
            o_cls.wall     = wfc_pkg::WALL_LEFT;
            o_cls.min_dist = l;
        end else if (c <= l && c < r) begin
            o_cls.wall     = wfc_pkg::WALL_CENTER;
            o_cls.min_dist = c;
        end else if (r <= c && r < l) begin
            o_cls.wall     = wfc_pkg::WALL_RIGHT;
            o_cls.min_dist = r;
        end else begin
            o_cls.wall     = wfc_pkg::WALL_LEFT;
            o_cls.min_dist = l;
        end
        o_cls.hold_on  = (o_cls.min_dist > i_cfg.hold_low) &&
                         (o_cls.min_dist < i_cfg.hold_high);
        o_cls.hold_far = (o_cls.min_dist >= i_cfg.hold_high);
        o_cls.obst     = (c < i_cfg.obstacle_near);
    end

endmodule

[design/wfc_queue.sv]
// Short FIFO of classified ticks between the front and back ends.
// Depends on wfc_pkg.
`timescale 1ns / 1ps

module wfc_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wfc_pkg::t_cls i_push_data,
    output logic          o_full,
    output logic          o_valid,
    output wfc_pkg::t_cls o_data,
    input  logic          i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wfc_pkg::t_cls    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    // Track fill level
    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // Store entries and advance pointers
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill level above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");

endmodule

[design/wfc_back.sv]
// Back end: stage machine that turns classified ticks into motor beats.
// Depends on wfc_pkg and wfc_chan_if.
`timescale 1ns / 1ps

module wfc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wfc_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  wfc_pkg::t_cls i_cls,
    output logic          o_pop,
    wfc_chan_if.source    o_motor
);

    typedef enum logic [1:0] {
        ST_SEARCH  = 2'd0,
        ST_FOLLOW  = 2'd1,
        ST_CORRECT = 2'd2,
        ST_ROTATE  = 2'd3
    } t_stage;

    t_stage                      r_stage, n_stage;
    wfc_pkg::t_wall              r_last_turn, n_last_turn;
    logic                        r_stopped, n_stopped;
    logic [wfc_pkg::DIST_W-1:0]  r_min, n_min;
    logic                        r_out_valid;
    wfc_pkg::t_motor             r_out;

    wfc_pkg::t_cmd               n_cmd;
    logic [wfc_pkg::SPEED_W-1:0] n_speed;
    logic                        want_move, leave;
    wfc_pkg::t_cmd               mv_cmd;
    wfc_pkg::t_wall              mv_code;
    t_stage                      leave_stage;
    logic                        search_on;

    // Take the next tick when the output register is free or being drained
    assign o_pop         = i_q_valid && (!r_out_valid || o_motor.ready);
    assign o_motor.valid = r_out_valid;
    assign o_motor.data  = r_out;

    assign search_on = (r_min > i_cfg.search_low) && (r_min < i_cfg.search_high);

    // Stage decisions
    always_comb begin
        n_stage     = r_stage;
        n_last_turn = r_last_turn;
        n_stopped   = r_stopped;
        n_min       = r_min;
        n_cmd       = wfc_pkg::CMD_NONE;
        n_speed     = '0;
        want_move   = 1'b0;
        mv_cmd      = wfc_pkg::CMD_NONE;
        mv_code     = wfc_pkg::WALL_NONE;
        leave       = 1'b0;
        leave_stage = ST_FOLLOW;

        unique case (r_stage)
            ST_SEARCH: begin
                if (!search_on) begin
                    n_min = i_cls.min_dist;
                    if (r_last_turn != i_cls.wall) begin
                        want_move = 1'b1;
                        mv_code   = i_cls.wall;
                        if (i_cls.wall == wfc_pkg::WALL_LEFT) begin
                            mv_cmd = wfc_pkg::CMD_LEFT;
                        end else if (i_cls.wall == wfc_pkg::WALL_CENTER) begin
                            mv_cmd = wfc_pkg::CMD_FWD;
                        end else begin
                            mv_cmd = wfc_pkg::CMD_RIGHT;
                        end
                    end
                end else begin
                    leave       = 1'b1;
                    leave_stage = ST_FOLLOW;
                end
            end
            ST_FOLLOW: begin
                n_min = i_cls.min_dist;
                if (i_cls.hold_on) begin
                    if (i_cls.wall != wfc_pkg::WALL_LEFT) begin
                        if (r_last_turn != wfc_pkg::WALL_RIGHT) begin
                            want_move = 1'b1;
                            mv_cmd    = wfc_pkg::CMD_RIGHT;
                            mv_code   = wfc_pkg::WALL_RIGHT;
                        end
                    end else if (r_last_turn != wfc_pkg::WALL_LEFT) begin
                        want_move = 1'b1;
                        mv_cmd    = wfc_pkg::CMD_FWD;
                        mv_code   = wfc_pkg::WALL_LEFT;
                    end
                end else begin
                    leave       = 1'b1;
                    leave_stage = ST_CORRECT;
                end
            end
            ST_CORRECT: begin
                n_min = i_cls.min_dist;
                if (!i_cls.hold_on) begin
                    if (i_cls.hold_far) begin
                        if (r_last_turn != wfc_pkg::WALL_RIGHT) begin
                            want_move = 1'b1;
                            mv_cmd    = wfc_pkg::CMD_LEFT;
                            mv_code   = wfc_pkg::WALL_RIGHT;
                        end
                    end else if (i_cls.obst) begin
                        n_stage = ST_ROTATE;
                    end else if (r_last_turn != wfc_pkg::WALL_LEFT) begin
                        want_move = 1'b1;
                        mv_cmd    = wfc_pkg::CMD_RIGHT;
                        mv_code   = wfc_pkg::WALL_LEFT;
                    end
                end else begin
                    leave       = 1'b1;
                    leave_stage = ST_FOLLOW;
                end
            end
            ST_ROTATE: begin
                if (i_cls.obst) begin
                    n_cmd     = wfc_pkg::CMD_RIGHT;
                    n_speed   = i_cfg.rotate_speed;
                    n_stopped = 1'b0;
                end else begin
                    leave       = 1'b1;
                    leave_stage = ST_FOLLOW;
                end
            end
            default: begin
                n_stage = ST_SEARCH;
            end
        endcase

        // Stop first; move only once already stopped
        if (want_move) begin
            if (!r_stopped) begin
                n_cmd     = wfc_pkg::CMD_STOP;
                n_stopped = 1'b1;
            end else begin
                n_cmd       = mv_cmd;
                n_speed     = i_cfg.cruise_speed;
                n_last_turn = mv_code;
                n_stopped   = 1'b0;
            end
        end

        // Leave the stage, stopping if moving
        if (leave) begin
            if (!r_stopped) begin
                n_cmd     = wfc_pkg::CMD_STOP;
                n_stopped = 1'b1;
            end
            n_last_turn = wfc_pkg::WALL_NONE;
            n_stage     = leave_stage;
        end
    end

    // Hold state and the output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= ST_SEARCH;
            r_last_turn <= wfc_pkg::WALL_NONE;
            r_stopped   <= 1'b1;
            r_min       <= wfc_pkg::RST_MIN_DIST;
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_stage             <= n_stage;
            r_last_turn         <= n_last_turn;
            r_stopped           <= n_stopped;
            r_min               <= n_min;
            r_out_valid         <= 1'b1;
            r_out.motor_command <= n_cmd;
            r_out.motor_speed   <= n_speed;
            r_out.stage_now     <= n_stage;
        end else if (o_motor.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    a_stop_sets_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && n_cmd == wfc_pkg::CMD_STOP |=> r_stopped)
        else $error("stop issued but stopped flag not set");

    a_quiet_no_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.motor_command == wfc_pkg::CMD_NONE ||
                        r_out.motor_command == wfc_pkg::CMD_STOP)
        |-> r_out.motor_speed == '0)
        else $error("speed nonzero on none or stop command");

    a_leave_clears_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && n_stage != r_stage && n_stage != ST_ROTATE
        |=> r_last_turn == wfc_pkg::WALL_NONE)
        else $error("stage change kept a last turn");

endmodule

[design/wall_follow_controller_unit.sv]
// A sensor beat is classified and queued, then the stage machine registers its motor beat.
// Throughput: one beat per cycle while the receiver is ready; the back-end stage machine
// decides combinationally, and the classification queue decouples input and output stalls.
// Reset (synchronous, active low): stage search, no last turn, stopped, minimum
// distance 255, queue and output empty, configuration back to its default values.
`timescale 1ns / 1ps

module wall_follow_controller_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    wfc_chan_if.sink                       i_sens,
    wfc_chan_if.source                     o_motor,
    input  logic                           i_cfg_we,
    input  logic [wfc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wfc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    wfc_pkg::t_cfg r_cfg;
    logic          q_full, q_valid, push, pop;
    wfc_pkg::t_cls push_cls, q_cls;

    // Configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cruise_speed  <= wfc_pkg::RST_CRUISE_SPEED;
            r_cfg.search_low    <= wfc_pkg::RST_SEARCH_LOW;
            r_cfg.search_high   <= wfc_pkg::RST_SEARCH_HIGH;
            r_cfg.hold_low      <= wfc_pkg::RST_HOLD_LOW;
            r_cfg.hold_high     <= wfc_pkg::RST_HOLD_HIGH;
            r_cfg.obstacle_near <= wfc_pkg::RST_OBSTACLE_NEAR;
            r_cfg.rotate_speed  <= wfc_pkg::RST_ROTATE_SPEED;
        end else if (i_cfg_we) begin
            unique case (wfc_pkg::t_cfg_idx'(i_cfg_idx))
                wfc_pkg::CFG_CRUISE_SPEED:  r_cfg.cruise_speed  <= i_cfg_data;
                wfc_pkg::CFG_SEARCH_LOW:    r_cfg.search_low    <= i_cfg_data[7:0];
                wfc_pkg::CFG_SEARCH_HIGH:   r_cfg.search_high   <= i_cfg_data[7:0];
                wfc_pkg::CFG_HOLD_LOW:      r_cfg.hold_low      <= i_cfg_data[7:0];
                wfc_pkg::CFG_HOLD_HIGH:     r_cfg.hold_high     <= i_cfg_data[7:0];
                wfc_pkg::CFG_OBSTACLE_NEAR: r_cfg.obstacle_near <= i_cfg_data[7:0];
                wfc_pkg::CFG_ROTATE_SPEED:  r_cfg.rotate_speed  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Classify incoming ticks
    wfc_front u_front (
        .i_sens   (i_sens),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cls    (push_cls)
    );

    // Decouple front and back
    wfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cls),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_data      (q_cls),
        .i_pop       (pop)
    );

    // Run the stage machine
    wfc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_cls     (q_cls),
        .o_pop     (pop),
        .o_motor   (o_motor)
    );

endmodule

[sim/wall_follow_controller_unit_tb.sv]
// Self-checking testbench for wall_follow_controller_unit: directed sensor ticks, then random ones.
// Depends on wfc_pkg, wfc_chan_if and the controller RTL; every motor beat is checked in order.
`timescale 1ns / 1ps

module wall_follow_controller_unit_tb;

    import wfc_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_REPORTS   = 10;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_TICKS   = 125;
    localparam int DIRECTED_N    = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    localparam logic [STAGE_W-1:0] ST_SEARCH  = 2'd0;
    localparam logic [STAGE_W-1:0] ST_FOLLOW  = 2'd1;
    localparam logic [STAGE_W-1:0] ST_CORRECT = 2'd2;
    localparam logic [STAGE_W-1:0] ST_ROTATE  = 2'd3;

    // One directed tick; the motor beat is typed in only where it is obvious
    typedef struct packed {
        t_sens  tick;
        logic   has_want;
        t_motor want;
    } t_row;

    // Walk all four stages with the reset thresholds (search 30..45, hold 35..45, obstacle 45)
    localparam t_row DIRECTED_ROWS [DIRECTED_N] = '{
        '{'{8'd255, 8'd0,   8'd255}, 1'b1, '{CMD_FWD, RST_CRUISE_SPEED, ST_SEARCH}},
        '{'{8'd40,  8'd100, 8'd100}, 1'b0, '0},  // new nearest wall while moving: stop
        '{'{8'd40,  8'd100, 8'd100}, 1'b0, '0},  // stored distance tested first: to follow
        '{'{8'd40,  8'd100, 8'd100}, 1'b0, '0},  // left wall in band: forward
        '{'{8'd100, 8'd40,  8'd100}, 1'b0, '0},  // center wall: stop first
        '{'{8'd100, 8'd40,  8'd100}, 1'b0, '0},  // then turn right
        '{'{8'd50,  8'd100, 8'd100}, 1'b0, '0},  // drifted off: stop, to correct
        '{'{8'd50,  8'd100, 8'd100}, 1'b0, '0},  // too far: turn left
        '{'{8'd30,  8'd100, 8'd100}, 1'b0, '0},  // too close, clear ahead: stop
        '{'{8'd30,  8'd100, 8'd100}, 1'b0, '0},  // then turn right
        '{'{8'd30,  8'd20,  8'd100}, 1'b0, '0},  // obstacle while correcting: rotate, no command
        '{'{8'd100, 8'd20,  8'd100}, 1'b0, '0},  // rotate right at rotate speed
        '{'{8'd100, 8'd100, 8'd100}, 1'b0, '0},  // clear ahead: stop, back to follow
        '{'{8'd40,  8'd40,  8'd40},  1'b0, '0},  // three-way tie goes left
        '{'{8'd0,   8'd255, 8'd0},   1'b0, '0},  // left equals right below center goes left
        '{'{8'd40,  8'd40,  8'd40},  1'b0, '0},  // back in band from correct: follow
        '{'{8'd255, 8'd255, 8'd255}, 1'b0, '0},  // leave follow while already stopped
        '{'{8'd0,   8'd0,   8'd255}, 1'b0, '0},  // close and blocked: rotate
        '{'{8'd255, 8'd0,   8'd0},   1'b0, '0},
        '{'{8'd0,   8'd255, 8'd255}, 1'b0, '0}
    };

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    wfc_chan_if #(.T(t_sens))  sens_if  ();
    wfc_chan_if #(.T(t_motor)) motor_if ();

    wall_follow_controller_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sens     (sens_if),
        .o_motor    (motor_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Controller model state and its copy of the registers
    logic [STAGE_W-1:0] ctl_stage     = ST_SEARCH;
    t_wall              ctl_last_turn = WALL_NONE;
    logic               ctl_stopped   = 1'b1;
    logic [DIST_W-1:0]  ctl_min_dist  = RST_MIN_DIST;
    t_cmd               ctl_cmd       = CMD_NONE;
    logic [SPEED_W-1:0] ctl_speed     = '0;

    logic [SPEED_W-1:0] reg_cruise_speed  = RST_CRUISE_SPEED;
    logic [DIST_W-1:0]  reg_search_low    = RST_SEARCH_LOW;
    logic [DIST_W-1:0]  reg_search_high   = RST_SEARCH_HIGH;
    logic [DIST_W-1:0]  reg_hold_low      = RST_HOLD_LOW;
    logic [DIST_W-1:0]  reg_hold_high     = RST_HOLD_HIGH;
    logic [DIST_W-1:0]  reg_obstacle_near = RST_OBSTACLE_NEAR;
    logic [SPEED_W-1:0] reg_rotate_speed  = RST_ROTATE_SPEED;

    t_motor pending_motor [$];
    int     mismatches  = 0;
    int     beats_seen  = 0;
    int     cycle_count = 0;
    bit     idle_on     = 1'b1;

    function automatic logic in_band(logic [DIST_W-1:0] d, logic [DIST_W-1:0] lo,
                                     logic [DIST_W-1:0] hi);
        return (d > lo) && (d < hi);
    endfunction

    // Pick the nearest wall and remember its distance; unhandled ties go left
    function automatic t_wall nearest_wall(t_sens s);
        if (s.dist_left <= s.dist_center && s.dist_left < s.dist_right) begin
            ctl_min_dist = s.dist_left;
            return WALL_LEFT;
        end
        if (s.dist_center <= s.dist_left && s.dist_center < s.dist_right) begin
            ctl_min_dist = s.dist_center;
            return WALL_CENTER;
        end
        if (s.dist_right <= s.dist_center && s.dist_right < s.dist_left) begin
            ctl_min_dist = s.dist_right;
            return WALL_RIGHT;
        end
        ctl_min_dist = s.dist_left;
        return WALL_LEFT;
    endfunction

    // Stop if moving, otherwise make the move
    function automatic void stop_then_move(t_cmd move, t_wall turn);
        if (!ctl_stopped) begin
            ctl_cmd     = CMD_STOP;
            ctl_speed   = '0;
            ctl_stopped = 1'b1;
        end else begin
            ctl_cmd       = move;
            ctl_speed     = reg_cruise_speed;
            ctl_last_turn = turn;
            ctl_stopped   = 1'b0;
        end
    endfunction

    function automatic void leave_stage(logic [STAGE_W-1:0] next);
        if (!ctl_stopped) begin
            ctl_cmd     = CMD_STOP;
            ctl_speed   = '0;
            ctl_stopped = 1'b1;
        end
        ctl_last_turn = WALL_NONE;
        ctl_stage     = next;
    endfunction

    // Advance the model by one sensor tick and return its motor beat
    function automatic t_motor predict_motor(t_sens s);
        t_wall wall;
        ctl_cmd   = CMD_NONE;
        ctl_speed = '0;
        case (ctl_stage)
            ST_SEARCH: begin
                if (!in_band(ctl_min_dist, reg_search_low, reg_search_high)) begin
                    wall = nearest_wall(s);
                    if (ctl_last_turn != wall) begin
                        stop_then_move(wall == WALL_LEFT ? CMD_LEFT :
                                       (wall == WALL_CENTER ? CMD_FWD : CMD_RIGHT), wall);
                    end
                end else begin
                    leave_stage(ST_FOLLOW);
                end
            end
            ST_FOLLOW: begin
                wall = nearest_wall(s);
                if (in_band(ctl_min_dist, reg_hold_low, reg_hold_high)) begin
                    if (wall != WALL_LEFT) begin
                        if (ctl_last_turn != WALL_RIGHT) stop_then_move(CMD_RIGHT, WALL_RIGHT);
                    end else begin
                        if (ctl_last_turn != WALL_LEFT) stop_then_move(CMD_FWD, WALL_LEFT);
                    end
                end else begin
                    leave_stage(ST_CORRECT);
                end
            end
            ST_CORRECT: begin
                wall = nearest_wall(s);
                if (!in_band(ctl_min_dist, reg_hold_low, reg_hold_high)) begin
                    if (ctl_min_dist >= reg_hold_high) begin
                        if (ctl_last_turn != WALL_RIGHT) stop_then_move(CMD_LEFT, WALL_RIGHT);
                    end else if (s.dist_center < reg_obstacle_near) begin
                        ctl_stage = ST_ROTATE;
                    end else if (ctl_last_turn != WALL_LEFT) begin
                        stop_then_move(CMD_RIGHT, WALL_LEFT);
                    end
                end else begin
                    leave_stage(ST_FOLLOW);
                end
            end
            default: begin
                if (s.dist_center < reg_obstacle_near) begin
                    ctl_cmd     = CMD_RIGHT;
                    ctl_speed   = reg_rotate_speed;
                    ctl_stopped = 1'b0;
                end else begin
                    leave_stage(ST_FOLLOW);
                end
            end
        endcase
        return '{motor_command: ctl_cmd, motor_speed: ctl_speed, stage_now: ctl_stage};
    endfunction

    // Mostly no gap, some short ones, a few long ones
    function automatic int gap_len();
        int pick;
        pick = int'($urandom_range(0, 99));
        if (pick < 55) return 0;
        if (pick < 90) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    // Distance close to one of the active thresholds or the stored minimum distance, or anywhere
    function automatic logic [DIST_W-1:0] near_dist();
        int base;
        int v;
        case ($urandom_range(0, 4))
            0: base = int'($urandom_range(0, 255));
            1: base = $urandom_range(0, 1) ? int'(reg_hold_low) : int'(reg_hold_high);
            2: base = $urandom_range(0, 1) ? int'(reg_search_low) : int'(reg_search_high);
            3: base = int'(reg_obstacle_near);
            default: base = int'(ctl_min_dist);
        endcase
        v = base + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    // Write one register at the next edge and mirror it in the model
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_CRUISE_SPEED:  reg_cruise_speed  = data;
            CFG_SEARCH_LOW:    reg_search_low    = data[DIST_W-1:0];
            CFG_SEARCH_HIGH:   reg_search_high   = data[DIST_W-1:0];
            CFG_HOLD_LOW:      reg_hold_low      = data[DIST_W-1:0];
            CFG_HOLD_HIGH:     reg_hold_high     = data[DIST_W-1:0];
            CFG_OBSTACLE_NEAR: reg_obstacle_near = data[DIST_W-1:0];
            CFG_ROTATE_SPEED:  reg_rotate_speed  = data;
            default: ;
        endcase
    endtask

    // Write every register, with junk in the unused upper bits and the spare index
    task automatic apply_cfg(input logic [SPEED_W-1:0] cruise_spd, input logic [DIST_W-1:0] s_lo,
                             input logic [DIST_W-1:0] s_hi, input logic [DIST_W-1:0] h_lo,
                             input logic [DIST_W-1:0] h_hi, input logic [DIST_W-1:0] obst,
                             input logic [SPEED_W-1:0] rot_spd);
        write_reg(CFG_CRUISE_SPEED, cruise_spd);
        write_reg(CFG_SEARCH_LOW, {2'($urandom_range(0, 3)), s_lo});
        write_reg(CFG_SEARCH_HIGH, {2'($urandom_range(0, 3)), s_hi});
        write_reg(CFG_HOLD_LOW, {2'($urandom_range(0, 3)), h_lo});
        write_reg(CFG_HOLD_HIGH, {2'($urandom_range(0, 3)), h_hi});
        write_reg(CFG_OBSTACLE_NEAR, {2'($urandom_range(0, 3)), obst});
        write_reg(CFG_ROTATE_SPEED, rot_spd);
        write_reg(CFG_IDX_UNUSED, 10'($urandom_range(0, 1023)));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Send one sensor beat after an optional gap and queue its motor beat
    task automatic send_tick(input t_sens tick, input logic has_want, input t_motor want);
        int     gap;
        t_motor predicted;
        gap = idle_on ? gap_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            sens_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        sens_if.valid <= 1'b1;
        sens_if.data  <= tick;
        do @(posedge i_clk); while (!sens_if.ready);
        predicted = predict_motor(tick);
        pending_motor.push_back(has_want ? want : predicted);
    endtask

    // Runs of a held reading so stop-then-move completes, plus some noise ticks
    task automatic random_ticks(input int count);
        t_sens tick;
        int    repeats;
        int    sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 5) == 0) begin
                tick.dist_left   = 8'($urandom_range(0, 255));
                tick.dist_center = 8'($urandom_range(0, 255));
                tick.dist_right  = 8'($urandom_range(0, 255));
                repeats = 1;
            end else begin
                tick.dist_left   = near_dist();
                tick.dist_center = near_dist();
                tick.dist_right  = near_dist();
                repeats = int'($urandom_range(1, 4));
            end
            repeat (repeats) begin
                send_tick(tick, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Hold off the sender until every motor beat is back, then let the pipe settle
    task automatic drain();
        @(negedge i_clk);
        sens_if.valid <= 1'b0;
        while (pending_motor.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver back-pressure
    initial begin
        int stall_left;
        stall_left     = 0;
        motor_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                motor_if.ready <= 1'b0;
                stall_left--;
            end else begin
                motor_if.ready <= 1'b1;
                if (idle_on) stall_left = gap_len();
            end
        end
    end

    // Compare each motor beat with the oldest prediction
    always @(posedge i_clk) begin
        t_motor got;
        t_motor want;
        if (i_rst_n && motor_if.valid && motor_if.ready) begin
            got = motor_if.data;
            if (pending_motor.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("motor beat %0d unexpected: cmd %0d speed %0d stage %0d",
                             beats_seen, got.motor_command, got.motor_speed, got.stage_now);
                end
            end else begin
                want = pending_motor.pop_front();
                if (got.motor_command !== want.motor_command ||
                    got.motor_speed !== want.motor_speed ||
                    got.stage_now !== want.stage_now) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("motor beat %0d: expected cmd %0d speed %0d stage %0d",
                                 beats_seen, want.motor_command, want.motor_speed,
                                 want.stage_now);
                        $display("motor beat %0d: got      cmd %0d speed %0d stage %0d",
                                 beats_seen, got.motor_command, got.motor_speed,
                                 got.stage_now);
                    end
                end
            end
            beats_seen++;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Main sequence
    initial begin
        int         phase;
        logic [7:0] s_lo;
        logic [7:0] h_lo;
        sens_if.valid = 1'b0;
        sens_if.data  = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk with the reset register values
        for (int row = 0; row < DIRECTED_N; row++) begin
            send_tick(DIRECTED_ROWS[row].tick, DIRECTED_ROWS[row].has_want,
                      DIRECTED_ROWS[row].want);
        end
        random_ticks(200);
        drain();

        // Extremes: all zero, widest bands at full speed, empty bands
        apply_cfg(10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 10'd0);
        random_ticks(100);
        drain();
        idle_on = 1'b0;
        apply_cfg(10'd1023, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 10'd1023);
        random_ticks(100);
        drain();
        idle_on = 1'b1;
        apply_cfg(10'($urandom_range(0, 1023)), 8'd40, 8'd40, 8'd50, 8'd20, 8'd45,
                  10'($urandom_range(0, 1023)));
        random_ticks(100);
        drain();

        // Random settings, mostly ordered bands, idling on in most phases
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            idle_on = ($urandom_range(0, 3) != 0);
            s_lo = 8'($urandom_range(0, 200));
            h_lo = 8'($urandom_range(0, 200));
            apply_cfg(10'($urandom_range(0, 1023)), s_lo, 8'(s_lo + $urandom_range(1, 55)),
                      h_lo, ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'(h_lo + $urandom_range(1, 55)),
                      8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)));
            random_ticks(PHASE_TICKS);
            drain();
        end

        if (mismatches == 0 && pending_motor.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
